/* design/lpip_pkg.sv */
// ----------------------------------------------------------------------------
// lpip_pkg - shared types and constants for the lidar point projection core
// Transfer payloads, sideband control word, status and register codes.
// ----------------------------------------------------------------------------
package lpip_pkg;

   // command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_POINT = 1'b1;

   // result status codes
   localparam logic [1:0] ST_RANGE = 2'd0;
   localparam logic [1:0] ST_OFF   = 2'd1;
   localparam logic [1:0] ST_BELOW = 2'd2;
   localparam logic [1:0] ST_LANE  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_M0_LO  = 3'd0;
   localparam logic [2:0] REG_M0_HI  = 3'd1;
   localparam logic [2:0] REG_M1_LO  = 3'd2;
   localparam logic [2:0] REG_M1_HI  = 3'd3;
   localparam logic [2:0] REG_M2_LO  = 3'd4;
   localparam logic [2:0] REG_M2_HI  = 3'd5;
   localparam logic [2:0] REG_SIZE   = 3'd6;
   localparam logic [2:0] REG_THRESH = 3'd7;

   // x range limit, 100 m in Q16.16
   localparam logic signed [31:0] X_LIMIT = 32'sd6553600;

   // reset values
   localparam logic [31:0] SIZE_RESET   = 32'd24577242;
   localparam logic [7:0]  THRESH_RESET = 8'd100;

   typedef struct packed {
      logic               command;
      logic [8:0]         pixel_row;
      logic [10:0]        pixel_col;
      logic [7:0]         pixel_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] image_col;
      logic [8:0]  image_row;
      logic [7:0]  pixel_seen;
   } rsp_type;

   // control word that rides along the pipeline
   typedef struct packed {
      logic        cmd;
      logic        in_range;
      logic        depth_pos;
      logic        neg0;
      logic        neg1;
      logic [8:0]  prow;
      logic [10:0] pcol;
      logic [7:0]  pval;
   } ctl_type;

endpackage

/* design/lpip_div.sv */
// ----------------------------------------------------------------------------
// lpip_div - pipelined restoring divider, two lanes sharing one divisor
// One quotient bit per stage after an overflow check; accepts a transfer
// every cycle unless out_ready stalls. Quotients over QB bits flag overflow.
// ----------------------------------------------------------------------------
module lpip_div import lpip_pkg::*; #(
   parameter int QB = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ctl_type       in_ctl,
   input  logic [64:0]   in_n0,
   input  logic [64:0]   in_n1,
   input  logic [63:0]   in_dd,
   output logic          out_valid,
   input  logic          out_ready,
   output ctl_type       out_ctl,
   output logic [QB-1:0] out_q0,
   output logic [QB-1:0] out_q1,
   output logic          out_ovf0,
   output logic          out_ovf1
);

   localparam int RW = 65 + QB;

   logic          v_ff   [QB+1];
   ctl_type       ctl_ff [QB+1];
   logic [RW-1:0] r0_ff  [QB+1];
   logic [RW-1:0] r1_ff  [QB+1];
   logic [63:0]   dd_ff  [QB+1];
   logic [QB-1:0] q0_ff  [QB+1];
   logic [QB-1:0] q1_ff  [QB+1];
   logic          o0_ff  [QB+1];
   logic          o1_ff  [QB+1];
   logic          rdy    [QB+2];

   assign rdy[QB+1] = out_ready;

   genvar k;
   generate
      for (k = 0; k <= QB; k++) begin : g_rdy
         assign rdy[k] = !v_ff[k] || rdy[k+1];
      end
   endgenerate

   assign in_ready = rdy[0];

   // entry stage: overflow check against divisor shifted by QB
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         v_ff[0] <= in_valid;
      end
      if (rdy[0] && in_valid) begin
         ctl_ff[0] <= in_ctl;
         r0_ff[0]  <= RW'(in_n0);
         r1_ff[0]  <= RW'(in_n1);
         dd_ff[0]  <= in_dd;
         q0_ff[0]  <= '0;
         q1_ff[0]  <= '0;
         o0_ff[0]  <= RW'(in_n0) >= (RW'(in_dd) << QB);
         o1_ff[0]  <= RW'(in_n1) >= (RW'(in_dd) << QB);
      end
   end

   // one quotient bit per stage, most significant first
   generate
      for (k = 1; k <= QB; k++) begin : g_stage
         localparam int J = QB - k;
         logic [RW-1:0] sub;
         logic          b0, b1;
         logic [QB-1:0] qn0, qn1;

         always_comb begin
            sub = RW'(dd_ff[k-1]) << J;
            b0  = r0_ff[k-1] >= sub;
            b1  = r1_ff[k-1] >= sub;
            qn0 = q0_ff[k-1];
            qn1 = q1_ff[k-1];
            qn0[J] = b0;
            qn1[J] = b1;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
            if (rdy[k] && v_ff[k-1]) begin
               ctl_ff[k] <= ctl_ff[k-1];
               r0_ff[k]  <= b0 ? r0_ff[k-1] - sub : r0_ff[k-1];
               r1_ff[k]  <= b1 ? r1_ff[k-1] - sub : r1_ff[k-1];
               dd_ff[k]  <= dd_ff[k-1];
               q0_ff[k]  <= qn0;
               q1_ff[k]  <= qn1;
               o0_ff[k]  <= o0_ff[k-1];
               o1_ff[k]  <= o1_ff[k-1];
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[QB];
   assign out_ctl   = ctl_ff[QB];
   assign out_q0    = q0_ff[QB];
   assign out_q1    = q1_ff[QB];
   assign out_ovf0  = o0_ff[QB];
   assign out_ovf1  = o1_ff[QB];

endmodule

/* design/lidar_point_image_projection_core.sv */
// ----------------------------------------------------------------------------
// lidar_point_image_projection_core - lidar point to camera pixel lane test
// Projects lidar points through a 3x4 camera matrix and checks the grey value
// stored at the resulting pixel; pixel writes fill the image store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transfer per item: a pixel write (command 0) or a
//   point (command 1). rsp_* returns one status transfer per point; pixel
//   writes produce none. csr_* is an APB-style port for the matrix, image
//   size and lane threshold, to be written by the user only while the core
//   is idle; the core itself does not enforce this.
// Pipeline: input register, multiply and sum stages, 1 + clog2(max(MAX_WIDTH,
//   MAX_HEIGHT)) divider stages, image store read and output register.
// Throughput: one item per cycle unless rsp_stall holds it; every stage is
//   a register and the image store has one write and one read port used by
//   the same lookup stage, so reads and writes happen in arrival order.
// Reset: clears pipeline valids and the registers to their defaults. The
//   image store is not cleared; pixels must be written before points read
//   them.
// Stall: a stalled result holds in the output register; upstream stages
//   keep filling bubbles and req_stall rises only once the pipeline is full.
// ----------------------------------------------------------------------------
module lidar_point_image_projection_core import lpip_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int QB    = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   // configuration registers
   logic [63:0] mat_ff [6];
   logic [31:0] size_ff;
   logic [7:0]  thr_ff;
   logic [2:0]  csr_idx;

   assign csr_idx    = csr_paddr[5:3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            mat_ff[i] <= '0;
         end
         size_ff <= SIZE_RESET;
         thr_ff  <= THRESH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            REG_M0_LO:  mat_ff[0] <= csr_pwdata;
            REG_M0_HI:  mat_ff[1] <= csr_pwdata;
            REG_M1_LO:  mat_ff[2] <= csr_pwdata;
            REG_M1_HI:  mat_ff[3] <= csr_pwdata;
            REG_M2_LO:  mat_ff[4] <= csr_pwdata;
            REG_M2_HI:  mat_ff[5] <= csr_pwdata;
            REG_SIZE:   size_ff   <= csr_pwdata[31:0];
            REG_THRESH: thr_ff    <= csr_pwdata[7:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_M0_LO:  csr_prdata = mat_ff[0];
         REG_M0_HI:  csr_prdata = mat_ff[1];
         REG_M1_LO:  csr_prdata = mat_ff[2];
         REG_M1_HI:  csr_prdata = mat_ff[3];
         REG_M2_LO:  csr_prdata = mat_ff[4];
         REG_M2_HI:  csr_prdata = mat_ff[5];
         REG_SIZE:   csr_prdata = {32'd0, size_ff};
         REG_THRESH: csr_prdata = {56'd0, thr_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // coefficient unpack
   logic signed [31:0] cf [3][4];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cf[r][0] = mat_ff[2*r][31:0];
         cf[r][1] = mat_ff[2*r][63:32];
         cf[r][2] = mat_ff[2*r+1][31:0];
         cf[r][3] = mat_ff[2*r+1][63:32];
      end
   end

   // pipeline handshake chain
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, sm_v_ff, rsp_v_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdym, rdyo;
   logic div_in_ready, div_out_valid;

   assign rdyo = !rsp_v_ff || !rsp_stall;
   assign rdym = !sm_v_ff || rdyo;
   assign rdy4 = !s4_v_ff || div_in_ready;
   assign rdy3 = !s3_v_ff || rdy4;
   assign rdy2 = !s2_v_ff || rdy3;
   assign rdy1 = !s1_v_ff || rdy2;
   assign req_stall = !rdy1;

   // stage 1: input register
   req_type s1_req_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (rdy1) begin
         s1_v_ff <= req_valid;
      end
      if (rdy1 && req_valid) begin
         s1_req_ff <= req_data;
      end
   end

   // stage 2: nine products and the offset term
   logic signed [63:0] p_ff [3][3];
   logic signed [63:0] c3_ff [3];
   ctl_type            ctl2_ff, ctl3_ff, ctl4_ff, ctl2_in;

   always_comb begin
      ctl2_in           = '0;
      ctl2_in.cmd       = s1_req_ff.command;
      ctl2_in.in_range  = !s1_req_ff.point_x[31] && (s1_req_ff.point_x <= X_LIMIT);
      ctl2_in.prow      = s1_req_ff.pixel_row;
      ctl2_in.pcol      = s1_req_ff.pixel_col;
      ctl2_in.pval      = s1_req_ff.pixel_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (rdy2) begin
         s2_v_ff <= s1_v_ff;
      end
      if (rdy2 && s1_v_ff) begin
         ctl2_ff <= ctl2_in;
         for (int r = 0; r < 3; r++) begin
            p_ff[r][0] <= cf[r][0] * s1_req_ff.point_x;
            p_ff[r][1] <= cf[r][1] * s1_req_ff.point_y;
            p_ff[r][2] <= cf[r][2] * s1_req_ff.point_z;
            c3_ff[r]   <= {{20{cf[r][3][31]}}, cf[r][3], 12'd0};
         end
      end
   end

   // stage 3: floor shift to Q.32 and pairwise sums
   logic signed [63:0] t_ff [3][2];
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (rdy3) begin
         s3_v_ff <= s2_v_ff;
      end
      if (rdy3 && s2_v_ff) begin
         ctl3_ff <= ctl2_ff;
         for (int r = 0; r < 3; r++) begin
            t_ff[r][0] <= (p_ff[r][0] >>> 4) + (p_ff[r][1] >>> 4);
            t_ff[r][1] <= (p_ff[r][2] >>> 4) + c3_ff[r];
         end
      end
   end

   // stage 4: row sums
   logic signed [63:0] s_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (rdy4) begin
         s4_v_ff <= s3_v_ff;
      end
      if (rdy4 && s3_v_ff) begin
         ctl4_ff <= ctl3_ff;
         for (int r = 0; r < 3; r++) begin
            s_ff[r] <= t_ff[r][0] + t_ff[r][1];
         end
      end
   end

   // rounding numerators 2*s + d and divisor 2*d
   logic signed [65:0] n0s, n1s, ds;
   ctl_type            div_ctl_in;
   always_comb begin
      ds  = {{2{s_ff[2][63]}}, s_ff[2]};
      n0s = ({{2{s_ff[0][63]}}, s_ff[0]} <<< 1) + ds;
      n1s = ({{2{s_ff[1][63]}}, s_ff[1]} <<< 1) + ds;
      div_ctl_in           = ctl4_ff;
      div_ctl_in.depth_pos = !s_ff[2][63] && (s_ff[2] != 64'sd0);
      div_ctl_in.neg0      = n0s[65];
      div_ctl_in.neg1      = n1s[65];
   end

   ctl_type         dv_ctl;
   logic [QB-1:0]   dv_q0, dv_q1;
   logic            dv_o0, dv_o1;

   lpip_div #(.QB(QB)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_v_ff),
      .in_ready  (div_in_ready),
      .in_ctl    (div_ctl_in),
      .in_n0     (n0s[64:0]),
      .in_n1     (n1s[64:0]),
      .in_dd     ({s_ff[2][62:0], 1'b0}),
      .out_valid (div_out_valid),
      .out_ready (rdym),
      .out_ctl   (dv_ctl),
      .out_q0    (dv_q0),
      .out_q1    (dv_q1),
      .out_ovf0  (dv_o0),
      .out_ovf1  (dv_o1)
   );

   // lookup: bounds check and image store access
   logic [16:0]   w_eff, h_eff;
   logic          col_ok, row_ok, hit, wr_ok, mv;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [1:0]    pre_status;

   always_comb begin
      w_eff = (size_ff[15:0] > 16'(MAX_WIDTH)) ? 17'(MAX_WIDTH) : {1'b0, size_ff[15:0]};
      h_eff = (size_ff[31:16] > 16'(MAX_HEIGHT)) ? 17'(MAX_HEIGHT) : {1'b0, size_ff[31:16]};
      col_ok = !dv_ctl.neg0 && !dv_o0 && (17'(dv_q0) < w_eff);
      row_ok = !dv_ctl.neg1 && !dv_o1 && (17'(dv_q1) < h_eff);
      hit    = dv_ctl.in_range && dv_ctl.depth_pos && col_ok && row_ok;
      pre_status = !dv_ctl.in_range ? ST_RANGE : ST_OFF;
      rd_addr = AW'(dv_q1 * MAX_WIDTH + dv_q0);
      wr_addr = AW'(dv_ctl.prow * MAX_WIDTH + dv_ctl.pcol);
      wr_ok   = (dv_ctl.prow < MAX_HEIGHT) && (dv_ctl.pcol < MAX_WIDTH);
      mv      = div_out_valid && rdym;
   end

   logic [7:0]    img_mem [DEPTH];
   logic [7:0]    rd_ff;
   logic          sm_hit_ff;
   logic [1:0]    sm_status_ff;
   logic [QB-1:0] sm_col_ff, sm_row_ff;

   // store write and read; both at the lookup transfer, so order is kept
   always_ff @(posedge clock) begin
      if (mv && dv_ctl.cmd == CMD_PIXEL && wr_ok) begin
         img_mem[wr_addr] <= dv_ctl.pval;
      end
      if (mv && dv_ctl.cmd == CMD_POINT && hit) begin
         rd_ff <= img_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_v_ff <= 1'b0;
      end else if (rdym) begin
         sm_v_ff <= div_out_valid && (dv_ctl.cmd == CMD_POINT);
      end
      if (mv) begin
         sm_hit_ff    <= hit;
         sm_status_ff <= pre_status;
         sm_col_ff    <= dv_q0;
         sm_row_ff    <= dv_q1;
      end
   end

   // output register with threshold compare
   rsp_type rsp_in, rsp_ff;
   always_comb begin
      rsp_in = '0;
      if (sm_hit_ff) begin
         rsp_in.status     = (rd_ff >= thr_ff) ? ST_LANE : ST_BELOW;
         rsp_in.image_col  = 11'(sm_col_ff);
         rsp_in.image_row  = 9'(sm_row_ff);
         rsp_in.pixel_seen = rd_ff;
      end else begin
         rsp_in.status = sm_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (rdyo) begin
         rsp_v_ff <= sm_v_ff;
      end
      if (rdyo && sm_v_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule
